// ----- design/brcbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brcbs_pkg;

  // Geometry of the bitmap store.
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = 32;
  localparam int WIDX_W     = 5;
  localparam int BIT_W      = 5;
  localparam int INDEX_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int OP_W       = 3;

  localparam logic [SIZE_W-1:0]    MAX_SIZE  = 11'd1024;
  localparam logic [BIT_W-1:0]     BIT_MAX   = 5'h1F;
  localparam logic [WORD_BITS-1:0] WORD_ONES = 32'hFFFFFFFF;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_SET_ALL     = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_RANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_FIRST  = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_LAST   = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE_BIT   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic decode;
    logic step;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk;
    logic hit;
    logic last;
    logic out_busy;
  } status_t;

  // Position of the lowest set bit, found from the isolated bit.
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     r;
    iso  = x & (~x + 32'd1);
    r[4] = |(iso & 32'hFFFF0000);
    r[3] = |(iso & 32'hFF00FF00);
    r[2] = |(iso & 32'hF0F0F0F0);
    r[1] = |(iso & 32'hCCCCCCCC);
    r[0] = |(iso & 32'hAAAAAAAA);
    return r;
  endfunction

  // Position of the highest set bit, by halving the word five times.
  function automatic logic [BIT_W-1:0] msb_index(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    logic [BIT_W-1:0]     r;
    v = x;
    r = '0;
    if (|v[31:16]) begin
      r[4] = 1'b1;
      v    = v >> 16;
    end
    if (|v[15:8]) begin
      r[3] = 1'b1;
      v    = v >> 8;
    end
    if (|v[7:4]) begin
      r[2] = 1'b1;
      v    = v >> 4;
    end
    if (|v[3:2]) begin
      r[1] = 1'b1;
      v    = v >> 2;
    end
    r[0] = v[1];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/brcbs_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brcbs_req_if;
  logic                         valid;
  logic                         ready;
  logic [brcbs_pkg::OP_W-1:0]   opcode;
  logic [brcbs_pkg::SIZE_W-1:0] first_index;
  logic [brcbs_pkg::INDEX_W-1:0] last_index;
  logic                         wanted_value;

  modport source (output valid, output opcode, output first_index, output last_index,
                  output wanted_value, input ready);
  modport sink (input valid, input opcode, input first_index, input last_index,
                input wanted_value, output ready);
endinterface

`default_nettype wire

// ----- design/brcbs_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brcbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [brcbs_pkg::INDEX_W-1:0] found_index;
  logic                          bad_request;

  modport source (output valid, output found, output found_index, output bad_request,
                  input ready);
  modport sink (input valid, input found, input found_index, input bad_request,
                output ready);
endinterface

`default_nettype wire

// ----- design/brcbs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brcbs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire brcbs_pkg::status_t st,
  output brcbs_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = st.walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (st.hit || st.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/brcbs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brcbs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  brcbs_req_if.sink                          req,
  brcbs_rsp_if.source                        rsp,
  input  wire logic                          cfg_we,
  input  wire logic [brcbs_pkg::SIZE_W-1:0]  cfg_wdata,
  input  wire brcbs_pkg::cmd_t               cmd,
  output brcbs_pkg::status_t                 st
);

  logic [brcbs_pkg::WORD_BITS-1:0] words [brcbs_pkg::WORD_COUNT];

  logic [brcbs_pkg::SIZE_W-1:0]  size_cfg;
  logic [brcbs_pkg::SIZE_W-1:0]  size_q;
  logic [brcbs_pkg::OP_W-1:0]    op_q;
  logic [brcbs_pkg::SIZE_W-1:0]  first_q;
  logic [brcbs_pkg::INDEX_W-1:0] last_q;
  logic                          want_q;

  logic [brcbs_pkg::WIDX_W-1:0]  ptr;
  logic [brcbs_pkg::WIDX_W-1:0]  lo_w;
  logic [brcbs_pkg::BIT_W-1:0]   lo_b;
  logic [brcbs_pkg::WIDX_W-1:0]  hi_w;
  logic [brcbs_pkg::BIT_W-1:0]   hi_b;

  logic                          res_found;
  logic [brcbs_pkg::INDEX_W-1:0] res_idx;
  logic                          res_bad;
  logic                          out_valid;

  // Decode of the held request.
  logic [brcbs_pkg::SIZE_W-1:0]  size_m1;
  logic [brcbs_pkg::SIZE_W-1:0]  start;
  logic [brcbs_pkg::SIZE_W-1:0]  last_ext;
  logic                          first_gt;
  logic                          first_ge;
  logic                          dec_bad;
  logic                          dec_walk;
  logic [brcbs_pkg::INDEX_W-1:0] dec_lo;
  logic [brcbs_pkg::INDEX_W-1:0] dec_hi;
  logic                          down;
  logic                          is_find;

  // One word of the walk.
  logic [brcbs_pkg::WORD_BITS-1:0] cur_word;
  logic [brcbs_pkg::WORD_BITS-1:0] lo_mask;
  logic [brcbs_pkg::WORD_BITS-1:0] hi_mask;
  logic [brcbs_pkg::WORD_BITS-1:0] word_mask;
  logic [brcbs_pkg::WORD_BITS-1:0] cand;
  logic [brcbs_pkg::BIT_W-1:0]     hit_bit;

  assign req.ready = cmd.take;

  always_comb begin
    size_m1  = size_q - 11'd1;
    last_ext = {1'b0, last_q};
    first_gt = first_q > size_q;
    first_ge = first_q >= size_q;
    start    = (first_q == size_q) ? size_m1 : first_q;
    dec_bad  = 1'b0;
    dec_walk = 1'b0;
    dec_lo   = first_q[brcbs_pkg::INDEX_W-1:0];
    dec_hi   = last_q;
    unique case (op_q) inside
      brcbs_pkg::OP_SET_ALL, brcbs_pkg::OP_CLEAR_ALL: begin
        dec_bad = 1'b0;
      end
      brcbs_pkg::OP_CLEAR_RANGE: begin
        dec_bad  = first_ge || (last_ext >= size_q) || (first_q > last_ext);
        dec_walk = !dec_bad;
      end
      brcbs_pkg::OP_FIND_FIRST: begin
        dec_bad  = first_gt;
        dec_walk = !first_ge;
        dec_hi   = size_m1[brcbs_pkg::INDEX_W-1:0];
      end
      brcbs_pkg::OP_FIND_LAST: begin
        dec_bad  = first_gt;
        dec_walk = !first_gt && (size_q != '0);
        dec_lo   = '0;
        dec_hi   = start[brcbs_pkg::INDEX_W-1:0];
      end
      brcbs_pkg::OP_WRITE_BIT: begin
        dec_bad = first_ge;
      end
      default: dec_bad = 1'b1;
    endcase
  end

  assign down    = (op_q == brcbs_pkg::OP_FIND_LAST);
  assign is_find = (op_q == brcbs_pkg::OP_FIND_FIRST) || down;

  always_comb begin
    cur_word  = words[ptr];
    lo_mask   = (ptr == lo_w) ? (brcbs_pkg::WORD_ONES << lo_b) : brcbs_pkg::WORD_ONES;
    hi_mask   = (ptr == hi_w) ? (brcbs_pkg::WORD_ONES >> (brcbs_pkg::BIT_MAX - hi_b))
                              : brcbs_pkg::WORD_ONES;
    word_mask = lo_mask & hi_mask;
    cand      = (want_q ? cur_word : ~cur_word) & word_mask;
    hit_bit   = down ? brcbs_pkg::msb_index(cand) : brcbs_pkg::lsb_index(cand);
  end

  assign st.walk     = dec_walk;
  assign st.hit      = is_find && (|cand);
  assign st.last     = down ? (ptr == lo_w) : (ptr == hi_w);
  assign st.out_busy = out_valid && !rsp.ready;

  // Size register, limited to the store's capacity when a request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= '0;
    end else if (cfg_we) begin
      size_cfg <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req.valid) begin
      op_q    <= req.opcode;
      first_q <= req.first_index;
      last_q  <= req.last_index;
      want_q  <= req.wanted_value;
      size_q  <= (size_cfg > brcbs_pkg::MAX_SIZE) ? brcbs_pkg::MAX_SIZE : size_cfg;
    end
    if (cmd.decode) begin
      lo_w <= dec_lo[brcbs_pkg::INDEX_W-1:brcbs_pkg::BIT_W];
      lo_b <= dec_lo[brcbs_pkg::BIT_W-1:0];
      hi_w <= dec_hi[brcbs_pkg::INDEX_W-1:brcbs_pkg::BIT_W];
      hi_b <= dec_hi[brcbs_pkg::BIT_W-1:0];
      ptr  <= down ? dec_hi[brcbs_pkg::INDEX_W-1:brcbs_pkg::BIT_W]
                   : dec_lo[brcbs_pkg::INDEX_W-1:brcbs_pkg::BIT_W];
    end else if (cmd.step) begin
      ptr <= down ? (ptr - 5'd1) : (ptr + 5'd1);
    end
    if (cmd.decode) begin
      res_bad   <= dec_bad;
      res_found <= 1'b0;
      res_idx   <= '0;
    end else if (cmd.step && st.hit) begin
      res_found <= 1'b1;
      res_idx   <= {ptr, hit_bit};
    end
  end

  // Bitmap store: whole-store fills, single-bit writes and masked range clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brcbs_pkg::WORD_COUNT; i++) begin
        words[i] <= '0;
      end
    end else if (cmd.decode && (op_q == brcbs_pkg::OP_SET_ALL)) begin
      for (int i = 0; i < brcbs_pkg::WORD_COUNT; i++) begin
        words[i] <= brcbs_pkg::WORD_ONES;
      end
    end else if (cmd.decode && (op_q == brcbs_pkg::OP_CLEAR_ALL)) begin
      for (int i = 0; i < brcbs_pkg::WORD_COUNT; i++) begin
        words[i] <= '0;
      end
    end else if (cmd.decode && (op_q == brcbs_pkg::OP_WRITE_BIT) && !dec_bad) begin
      words[first_q[brcbs_pkg::INDEX_W-1:brcbs_pkg::BIT_W]][first_q[brcbs_pkg::BIT_W-1:0]]
        <= want_q;
    end else if (cmd.step && (op_q == brcbs_pkg::OP_CLEAR_RANGE)) begin
      words[ptr] <= cur_word & ~word_mask;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp.found       <= res_found;
      rsp.found_index <= res_idx;
      rsp.bad_request <= res_bad;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ----- design/bitmap_range_clear_and_bit_search.sv -----
// Bitmap of 1024 bits kept as 32 words of 32 bits, with range clear and bit search.
// Requests arrive on the req channel (opcode, first_index, last_index, wanted_value)
// and each one produces exactly one transfer on the rsp channel (found, found_index,
// bad_request). Both channels move a transfer when valid and ready are high together.
// The size register is written through cfg_we / cfg_wdata, by the user only while the block is
// idle (the block itself does not enforce this); values above 1024 are treated as 1024.
// A request is taken only when the previous one has left its working registers.
// Set all, clear all, single-bit writes and rejected requests pass from decode straight
// to the done state, which hands the result to the output register and returns to idle.
// Range clears and searches walk the store one word per cycle through the single
// word read port, visiting at most 32 words; a search stops at the first word
// holding a match.
// The result sits in an output register. When the receiver stalls, the next result
// waits in the working registers until the output register frees up.
// Synchronous reset clears the whole bitmap, the size register and all handshake
// state; the block accepts a request in the first cycle after reset.

`timescale 1ns / 1ps
`default_nettype none

module bitmap_range_clear_and_bit_search (
  input  wire logic                         clk,
  input  wire logic                         rst,
  brcbs_req_if.sink                         req,
  brcbs_rsp_if.source                       rsp,
  input  wire logic                         cfg_we,
  input  wire logic [brcbs_pkg::SIZE_W-1:0] cfg_wdata
);

  brcbs_pkg::cmd_t    cmd;
  brcbs_pkg::status_t st;

  // The controller sequences accept, decode, word walk and result hand-off.
  brcbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the bitmap, the request, the walk pointer and the output register.
  brcbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
